// File: sv/label_centroid_accumulator_assert.svh
// Assertion macros for label_centroid_accumulator.
// Included by the top level; the properties use its clk_i and rst_ni.
`ifndef LABEL_CENTROID_ACCUMULATOR_ASSERT_SVH
`define LABEL_CENTROID_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTH

`define LCA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define LCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCA_ASSERT_IMPL(name, ante, cons, msg)

`define LCA_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: sv/lca_pkg.sv
// Package for label_centroid_accumulator: widths, codes, word and entry types.
// No dependencies.
`timescale 1ns / 1ps

package lca_pkg;

  localparam int unsigned LCA_MAX_LABELS = 256;
  localparam int unsigned LCA_MAX_DIM    = 1024;
  localparam int unsigned LCA_FRAC_BITS  = 8;

  localparam int unsigned LABEL_W = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned OBJ_W   = 9;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned SUM_W   = 31;
  localparam int unsigned OUT_W   = 18;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } lca_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } lca_status_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } lca_div_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } lca_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] centroid_row;
    logic [OUT_W-1:0] centroid_col;
    logic [1:0]       status;
  } lca_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] col_sum;
  } lca_entry_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lca_div_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lca_div_sts_t;

endpackage

// File: sv/lca_div.sv
// Two-lane restoring divider: (sum << FRAC_BITS) / count, one quotient bit per cycle.
// Quotients saturate to the output width. Depends on lca_pkg.
`timescale 1ns / 1ps

module lca_div #(
  parameter int unsigned FRAC_BITS = lca_pkg::LCA_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lca_pkg::lca_div_ctl_t       ctl_i,
  output lca_pkg::lca_div_sts_t       sts_o,
  input  logic [lca_pkg::SUM_W-1:0]   row_sum_i,
  input  logic [lca_pkg::SUM_W-1:0]   col_sum_i,
  input  logic [lca_pkg::CNT_W-1:0]   count_i,
  output logic [lca_pkg::OUT_W-1:0]   quo_row_o,
  output logic [lca_pkg::OUT_W-1:0]   quo_col_o
);

  localparam int unsigned DW = lca_pkg::SUM_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);
  localparam int unsigned NW = lca_pkg::CNT_W;
  localparam int unsigned OUT_W_SAT = lca_pkg::OUT_W;

  lca_pkg::lca_div_state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  logic [NW-1:0] den_q;
  logic [DW-1:0] num_q [2];
  logic [DW-1:0] quo_q [2];
  logic [NW-1:0] rem_q [2];
  logic [DW-1:0] num_d [2];
  logic [DW-1:0] quo_d [2];
  logic [NW-1:0] rem_d [2];
  logic [OUT_W_SAT-1:0] unused_sat;

  always_comb begin
    logic [NW:0] trial;
    logic        ge;
    trial = '0;
    ge    = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_q[i], num_q[i][DW-1]};
      ge       = trial >= {1'b0, den_q};
      rem_d[i] = ge ? NW'(trial - {1'b0, den_q}) : trial[NW-1:0];
      num_d[i] = {num_q[i][DW-2:0], 1'b0};
      quo_d[i] = {quo_q[i][DW-2:0], ge};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lca_pkg::DIV_IDLE: begin
        if (ctl_i.start) state_d = lca_pkg::DIV_RUN;
      end
      lca_pkg::DIV_RUN: begin
        if (cnt_q == CW'(1)) state_d = lca_pkg::DIV_DONE;
      end
      lca_pkg::DIV_DONE: begin
        if (ctl_i.ack) state_d = lca_pkg::DIV_IDLE;
      end
      default: state_d = lca_pkg::DIV_IDLE;
    endcase
    sts_o.idle = (state_q == lca_pkg::DIV_IDLE);
    sts_o.done = (state_q == lca_pkg::DIV_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lca_pkg::DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lca_pkg::DIV_IDLE && ctl_i.start) begin
      cnt_q    <= CW'(DW);
      den_q    <= count_i;
      num_q[0] <= DW'(row_sum_i) << FRAC_BITS;
      num_q[1] <= DW'(col_sum_i) << FRAC_BITS;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      quo_q[0] <= '0;
      quo_q[1] <= '0;
    end else if (state_q == lca_pkg::DIV_RUN) begin
      cnt_q <= cnt_q - CW'(1);
      for (int i = 0; i < 2; i++) begin
        num_q[i] <= num_d[i];
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign unused_sat = '0;

  assign quo_row_o = (quo_q[0][DW-1:OUT_W_SAT] != '0) ? {OUT_W_SAT{1'b1}}
                                                      : quo_q[0][OUT_W_SAT-1:0] | unused_sat;
  assign quo_col_o = (quo_q[1][DW-1:OUT_W_SAT] != '0) ? {OUT_W_SAT{1'b1}}
                                                      : quo_q[1][OUT_W_SAT-1:0];

endmodule

// File: sv/label_centroid_accumulator.sv
// Per-label centroid engine: count/sum store with read-modify-write, plus divider.
// Depends on lca_pkg, lca_div and label_centroid_accumulator_assert.svh.
//
//   channel | direction | handshake                   | word
//   in      | input     | in_valid_i / in_stall_o     | in_word_i  (lca_in_t)
//   out     | output    | out_valid_o / out_stall_i   | out_word_o (lca_out_t)
//   cfg     | input     | cfg_we_i                    | cfg_wdata_i (object_count)
//
// Clear, pixel, out-of-range and unused words: one per cycle unless output stalls;
// each passes stage 1 and the output register. A query on a non-empty, in-range
// label runs the divider, one quotient bit per cycle; input stalls meanwhile.
// Reset and clear take effect at once through per-entry valid bits; no wipe pass.
// Same-label pixels back to back are forwarded from the write in flight.
`timescale 1ns / 1ps
`include "label_centroid_accumulator_assert.svh"

module label_centroid_accumulator #(
  parameter int unsigned MAX_LABELS = lca_pkg::LCA_MAX_LABELS,
  parameter int unsigned FRAC_BITS  = lca_pkg::LCA_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lca_pkg::lca_in_t          in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lca_pkg::lca_out_t         out_word_o,
  input  logic                      cfg_we_i,
  input  logic [lca_pkg::OBJ_W-1:0] cfg_wdata_i
);

  localparam int unsigned LBL_SPAN = 2 ** lca_pkg::LABEL_W;
  localparam int unsigned DEPTH    = (MAX_LABELS < LBL_SPAN) ? MAX_LABELS : LBL_SPAN;
  localparam int unsigned AW       = $clog2(DEPTH);

  lca_pkg::lca_entry_t mem_q [DEPTH];
  logic [DEPTH-1:0]    vbit_q;

  logic [lca_pkg::OBJ_W-1:0] obj_cnt_q;

  logic                s1_vld_q;
  lca_pkg::lca_in_t    s1_q;
  logic                s1_hit_q;
  logic                s1_vbit_q;
  lca_pkg::lca_entry_t s1_fwd_q;
  lca_pkg::lca_entry_t rd_q;

  logic              out_vld_q;
  lca_pkg::lca_out_t out_q;
  lca_pkg::lca_out_t res;

  logic                in_acc;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       s1_addr;
  lca_pkg::lca_entry_t cur;
  logic                in_range;
  logic                is_pixel;
  logic                is_query;
  logic                need_div;
  logic                out_can_load;
  logic                s1_retire;
  logic                wr_en;
  lca_pkg::lca_entry_t wr_data;
  logic [lca_pkg::COORD_W-1:0] row_c;
  logic [lca_pkg::COORD_W-1:0] col_c;

  lca_pkg::lca_div_ctl_t     div_ctl;
  lca_pkg::lca_div_sts_t     div_sts;
  logic [lca_pkg::OUT_W-1:0] quo_row;
  logic [lca_pkg::OUT_W-1:0] quo_col;

  assign in_addr = in_word_i.label[AW-1:0];
  assign s1_addr = s1_q.label[AW-1:0];

  assign cur = s1_hit_q ? s1_fwd_q : (s1_vbit_q ? rd_q : '0);

  assign in_range = ({1'b0, s1_q.label} < obj_cnt_q) && (32'(s1_q.label) < MAX_LABELS);
  assign is_pixel = (s1_q.opcode == lca_pkg::OP_PIXEL);
  assign is_query = (s1_q.opcode == lca_pkg::OP_QUERY);
  assign need_div = is_query && in_range && (cur.count != '0);

  assign row_c = (32'(s1_q.row) >= lca_pkg::LCA_MAX_DIM) ?
                 lca_pkg::COORD_W'(lca_pkg::LCA_MAX_DIM - 1) : s1_q.row;
  assign col_c = (32'(s1_q.col) >= lca_pkg::LCA_MAX_DIM) ?
                 lca_pkg::COORD_W'(lca_pkg::LCA_MAX_DIM - 1) : s1_q.col;

  assign out_can_load = !out_vld_q || !out_stall_i;
  assign s1_retire    = s1_vld_q && out_can_load && (!need_div || div_sts.done);
  assign in_stall_o   = s1_vld_q && !s1_retire;
  assign in_acc       = in_valid_i && !in_stall_o;

  assign wr_en = s1_retire && is_pixel && in_range && (cur.count != lca_pkg::COUNT_MAX);
  always_comb begin
    wr_data.count   = cur.count + lca_pkg::CNT_W'(1);
    wr_data.row_sum = cur.row_sum + lca_pkg::SUM_W'(row_c);
    wr_data.col_sum = cur.col_sum + lca_pkg::SUM_W'(col_c);
  end

  assign div_ctl.start = s1_vld_q && need_div && div_sts.idle;
  assign div_ctl.ack   = s1_retire && need_div;

  lca_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .sts_o     (div_sts),
    .row_sum_i (cur.row_sum),
    .col_sum_i (cur.col_sum),
    .count_i   (cur.count),
    .quo_row_o (quo_row),
    .quo_col_o (quo_col)
  );

  always_comb begin
    res.centroid_row = '0;
    res.centroid_col = '0;
    res.status       = lca_pkg::ST_OK;
    if ((is_pixel || is_query) && !in_range) begin
      res.status = lca_pkg::ST_RANGE;
    end else if (is_query && cur.count == '0) begin
      res.status = lca_pkg::ST_EMPTY;
    end else if (is_query) begin
      res.centroid_row = quo_row;
      res.centroid_col = quo_col;
    end
  end

  // store: write from stage 1, read at accept
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= mem_q[in_addr];
    end
  end

  // clear wins over a pixel write retiring at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q <= '0;
    end else if (in_acc && in_word_i.opcode == lca_pkg::OP_CLEAR) begin
      vbit_q <= '0;
    end else if (wr_en) begin
      vbit_q[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= in_word_i;
      s1_vbit_q <= vbit_q[in_addr];
      s1_hit_q  <= wr_en && (s1_addr == in_addr);
      s1_fwd_q  <= wr_data;
    end
    if (s1_retire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        obj_cnt_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_retire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_retire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  `LCA_ASSERT_IMPL(a_div_start_query, div_ctl.start, s1_vld_q && is_query && in_range, "divider started without a valid query")
  `LCA_ASSERT_NEXT(a_clear_wipes, in_acc && (in_word_i.opcode == lca_pkg::OP_CLEAR), vbit_q == '0, "clear left valid entries")
  `LCA_ASSERT_IMPL(a_out_from_s1, $rose(out_vld_q), $past(s1_vld_q), "result word without an item in stage 1")

endmodule

// File: tb/label_centroid_accumulator_test.sv
// Testbench for label_centroid_accumulator: random and directed words against a predictor.
// A scoreboard class predicts counts, sums and centroids; depends on lca_pkg and the block.
`timescale 1ns / 1ps

module label_centroid_accumulator_test;
  import lca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  class centroid_scoreboard;
    bit [OBJ_W-1:0]   object_count;
    bit [CNT_W-1:0]   pix_count [LCA_MAX_LABELS];
    bit [SUM_W-1:0]   row_total [LCA_MAX_LABELS];
    bit [SUM_W-1:0]   col_total [LCA_MAX_LABELS];
    lca_out_t         pending_results[$];
    int unsigned      errors;

    function new();
      object_count = '0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < LCA_MAX_LABELS; i++) begin
        pix_count[i] = '0;
        row_total[i] = '0;
        col_total[i] = '0;
      end
    endfunction

    function bit label_in_range(int unsigned k);
      return k < object_count && k < LCA_MAX_LABELS;
    endfunction

    function bit [COORD_W-1:0] clamp_coord(bit [COORD_W-1:0] c);
      return (c >= LCA_MAX_DIM) ? COORD_W'(LCA_MAX_DIM - 1) : c;
    endfunction

    function bit [OUT_W-1:0] fixed_quot(bit [SUM_W-1:0] s, bit [CNT_W-1:0] n);
      longint unsigned sl;
      longint unsigned q;
      sl = s;
      q = (sl << LCA_FRAC_BITS) / n;
      return (q > OUT_MAX) ? OUT_MAX : q[OUT_W-1:0];
    endfunction

    function void note_word(lca_in_t w);
      lca_out_t r;
      int unsigned k;
      r = '0;
      r.status = ST_OK;
      k = w.label;
      case (w.opcode)
        OP_CLEAR: wipe();
        OP_PIXEL: begin
          if (!label_in_range(k)) begin
            r.status = ST_RANGE;
          end else if (pix_count[k] != COUNT_MAX) begin
            pix_count[k] = pix_count[k] + 1'b1;
            row_total[k] = row_total[k] + clamp_coord(w.row);
            col_total[k] = col_total[k] + clamp_coord(w.col);
          end
        end
        OP_QUERY: begin
          if (!label_in_range(k)) begin
            r.status = ST_RANGE;
          end else if (pix_count[k] == '0) begin
            r.status = ST_EMPTY;
          end else begin
            r.centroid_row = fixed_quot(row_total[k], pix_count[k]);
            r.centroid_col = fixed_quot(col_total[k], pix_count[k]);
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(lca_out_t got);
      lca_out_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: row %0d col %0d status %0d",
                   got.centroid_row, got.centroid_col, got.status);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.centroid_row !== exp_r.centroid_row || got.centroid_col !== exp_r.centroid_col ||
          got.status !== exp_r.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected row %0d col %0d status %0d, got row %0d col %0d status %0d",
                   exp_r.centroid_row, exp_r.centroid_col, exp_r.status,
                   got.centroid_row, got.centroid_col, got.status);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  lca_in_t          in_word_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  lca_out_t         out_word_o;
  logic             cfg_we_i = 1'b0;
  logic [OBJ_W-1:0] cfg_wdata_i = '0;

  centroid_scoreboard sb;
  int unsigned cycle_count = 0;
  bit quiet = 1'b0;
  bit hold_now = 1'b0;

  label_centroid_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("label_centroid_accumulator_test: done, errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic lca_in_t make_word(lca_op_e op, int unsigned lab, int unsigned r,
                                        int unsigned c);
    lca_in_t w;
    w.opcode = op;
    w.label  = lab[LABEL_W-1:0];
    w.row    = r[COORD_W-1:0];
    w.col    = c[COORD_W-1:0];
    return w;
  endfunction

  function automatic int unsigned rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 1023 : 0;
    return $urandom_range(0, 1023);
  endfunction

  function automatic lca_in_t rand_word();
    int unsigned r;
    int unsigned span;
    int unsigned lab;
    lca_op_e op;
    r = $urandom_range(0, 99);
    if (r < 78) op = OP_PIXEL;
    else if (r < 94) op = OP_QUERY;
    else if (r < 97) op = OP_UNUSED;
    else op = OP_CLEAR;
    span = (sb.object_count < LCA_MAX_LABELS) ? sb.object_count : LCA_MAX_LABELS;
    r = $urandom_range(0, 99);
    if (span > 0 && r < 40) lab = $urandom_range(0, (span < 8 ? span : 8) - 1);
    else if (span > 0 && r < 75) lab = $urandom_range(0, span - 1);
    else lab = $urandom_range(0, 255);
    return make_word(op, lab, rand_coord(), rand_coord());
  endfunction

  task automatic send_word(lca_in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_word(w);
  endtask

  task automatic pause_for_results();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_object_count(int unsigned v);
    pause_for_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[OBJ_W-1:0];
    @(negedge clk_i) cfg_we_i <= 1'b0;
    sb.object_count = v[OBJ_W-1:0];
  endtask

  // result side: random stall, with one long hold-off on request
  initial begin
    int unsigned n;
    int unsigned run;
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      @(negedge clk_i) out_stall_i <= 1'b0;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) sb.check_result(out_word_o);
  end

  initial begin
    int unsigned oc_plan [8];
    sb = new();
    oc_plan = '{256, 0, 1, 511, 256, 0, 0, 256};
    oc_plan[5] = $urandom_range(2, 256);
    oc_plan[6] = $urandom_range(0, 511);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of object_count rejects everything
    send_word(make_word(OP_PIXEL, 0, 3, 4));
    send_word(make_word(OP_QUERY, 0, 0, 0));
    write_object_count(256);
    send_word(make_word(OP_QUERY, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 1023, 1023));
    send_word(make_word(OP_QUERY, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 255, 1023, 0));
    send_word(make_word(OP_PIXEL, 255, 0, 1023));
    send_word(make_word(OP_PIXEL, 255, 1023, 1023));
    send_word(make_word(OP_QUERY, 255, 0, 0));
    send_word(make_word(OP_UNUSED, 255, 1023, 1023));
    send_word(make_word(OP_QUERY, 255, 1023, 1023));
    send_word(make_word(OP_CLEAR, 255, 1023, 1023));
    send_word(make_word(OP_QUERY, 0, 0, 0));
    send_word(make_word(OP_QUERY, 255, 0, 0));
    send_word(make_word(OP_PIXEL, 7, 5, 9));
    send_word(make_word(OP_QUERY, 7, 0, 0));
    write_object_count(511);
    send_word(make_word(OP_PIXEL, 255, 700, 300));
    send_word(make_word(OP_QUERY, 255, 0, 0));
    write_object_count(1);
    send_word(make_word(OP_PIXEL, 1, 10, 10));
    send_word(make_word(OP_PIXEL, 0, 10, 20));
    send_word(make_word(OP_QUERY, 1, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, 0));

    for (int p = 0; p < 8; p++) begin
      write_object_count(oc_plan[p]);
      quiet = (p == 5);
      for (int i = 0; i < 100; i++) begin
        if (p == 4 && i == 10) hold_now = 1'b1;
        if (p == 6 && i == 50) pause_for_results();
        send_word(rand_word());
      end
    end
    quiet = 1'b0;

    pause_for_results();
    repeat (40) @(posedge clk_i);
    sb.errors += sb.pending_results.size();
    if (sb.errors == 0) begin
      $display("label_centroid_accumulator_test: done, clean");
    end else begin
      $display("label_centroid_accumulator_test: done, errors");
    end
    $finish;
  end

endmodule

// File: label_centroid_accumulator.f
+incdir+sv
sv/lca_pkg.sv
sv/lca_div.sv
sv/label_centroid_accumulator.sv
tb/label_centroid_accumulator_test.sv
